// ===== rtl/eskmt_pkg.sv =====
// ----------------------------------------------------------------------------
// eskmt_pkg
// Shared types and constants of the escape-sequence keyboard-mode tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package eskmt_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CSI_LIMIT   = 64;
  localparam int PCNT_W      = $clog2(CSI_LIMIT + 1);
  localparam int DEPTH_W     = 7;
  localparam int OUT_W       = 2 + 32 + DEPTH_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_SUB  = 8'h1a;
  localparam logic [7:0] B_ESC  = 8'h1b;
  localparam logic [7:0] B_BEL  = 8'h07;
  localparam logic [7:0] B_ST   = 8'h9c;
  localparam logic [7:0] B_CSI  = 8'h9b;
  localparam logic [7:0] B_OSC  = 8'h9d;
  localparam logic [7:0] B_DCS  = 8'h90;
  localparam logic [7:0] B_SOS  = 8'h98;
  localparam logic [7:0] B_PM   = 8'h9e;
  localparam logic [7:0] B_APC  = 8'h9f;

  localparam logic [31:0] FLAG_MASK = 32'd9;

  typedef enum logic [8:0] {
    PH_GROUND    = 9'b000000001,
    PH_ESC       = 9'b000000010,
    PH_ESC_INTER = 9'b000000100,
    PH_CSI       = 9'b000001000,
    PH_CSI_IGN   = 9'b000010000,
    PH_OSC       = 9'b000100000,
    PH_OSC_ESC   = 9'b001000000,
    PH_STR       = 9'b010000000,
    PH_STR_ESC   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        set_scr;
    logic        scr_val;
    logic        clear;
    logic [31:0] value;
  } stk_cmd_t;

  // largest value that may still take digit d without passing 2^32-1
  function automatic logic [31:0] digit_limit(input logic [3:0] d);
    logic [31:0] lim;
    unique case (d)
      4'd0:    lim = (32'hFFFFFFFF - 32'd0) / 10;
      4'd1:    lim = (32'hFFFFFFFF - 32'd1) / 10;
      4'd2:    lim = (32'hFFFFFFFF - 32'd2) / 10;
      4'd3:    lim = (32'hFFFFFFFF - 32'd3) / 10;
      4'd4:    lim = (32'hFFFFFFFF - 32'd4) / 10;
      4'd5:    lim = (32'hFFFFFFFF - 32'd5) / 10;
      4'd6:    lim = (32'hFFFFFFFF - 32'd6) / 10;
      4'd7:    lim = (32'hFFFFFFFF - 32'd7) / 10;
      4'd8:    lim = (32'hFFFFFFFF - 32'd8) / 10;
      default: lim = (32'hFFFFFFFF - 32'd9) / 10;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eskmt_parser.sv =====
// ----------------------------------------------------------------------------
// eskmt_parser
// Escape parser; turns each accepted byte into a stack command.
// ----------------------------------------------------------------------------
`default_nettype none

module eskmt_parser import eskmt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output stk_cmd_t        cmd
);

  phase_t            phase_r, phase_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [PCNT_W-1:0] icnt_r, icnt_nxt;
  logic [7:0]        marker_r, marker_nxt;
  logic [31:0]       whole_r, whole_nxt;
  logic              whole_ok_r, whole_ok_nxt;
  logic [31:0]       field_r, field_nxt;
  logic              field_ok_r, field_ok_nxt;
  logic              seen_r, seen_nxt;
  logic              failed_r, failed_nxt;

  logic        cancel;
  logic [3:0]  dig;
  logic        fld_match;
  logic        fin_seen;
  logic        empty;

  assign cancel = (in_byte == B_CAN) || (in_byte == B_SUB);
  assign dig    = in_byte[3:0];
  assign fld_match = field_ok_r &&
                     (field_r == 32'd47 || field_r == 32'd1047 || field_r == 32'd1049);
  assign fin_seen = seen_r || (!failed_r && fld_match);
  assign empty    = (pcnt_r <= PCNT_W'(1));

  always_comb begin
    phase_nxt    = phase_r;
    pcnt_nxt     = pcnt_r;
    icnt_nxt     = icnt_r;
    marker_nxt   = marker_r;
    whole_nxt    = whole_r;
    whole_ok_nxt = whole_ok_r;
    field_nxt    = field_r;
    field_ok_nxt = field_ok_r;
    seen_nxt     = seen_r;
    failed_nxt   = failed_r;
    cmd          = '0;

    unique case (phase_r)
      PH_ESC: begin
        if (cancel) begin
          phase_nxt = PH_GROUND;
        end else if (in_byte == B_ESC) begin
          phase_nxt = PH_ESC;
        end else if (in_byte == "[") begin
          phase_nxt    = PH_CSI;
          pcnt_nxt     = '0;
          icnt_nxt     = '0;
          marker_nxt   = '0;
          whole_nxt    = '0;
          whole_ok_nxt = 1'b1;
          field_nxt    = '0;
          field_ok_nxt = 1'b1;
          seen_nxt     = 1'b0;
          failed_nxt   = 1'b0;
        end else if (in_byte == "]") begin
          phase_nxt = PH_OSC;
        end else if (in_byte == "P" || in_byte == "X" || in_byte == "^" ||
                     in_byte == "_") begin
          phase_nxt = PH_STR;
        end else if (in_byte == "c") begin
          cmd.clear = 1'b1;
          phase_nxt = PH_GROUND;
        end else if (in_byte >= 8'h20 && in_byte <= 8'h2f) begin
          phase_nxt = PH_ESC_INTER;
        end else if (in_byte >= 8'h30 && in_byte <= 8'h7e) begin
          phase_nxt = PH_GROUND;
        end
      end
      PH_ESC_INTER: begin
        if (cancel || (in_byte >= 8'h30 && in_byte <= 8'h7e)) begin
          phase_nxt = PH_GROUND;
        end else if (in_byte == B_ESC) begin
          phase_nxt = PH_ESC;
        end
      end
      PH_CSI: begin
        if (cancel) begin
          phase_nxt = PH_GROUND;
        end else if (in_byte == B_ESC) begin
          phase_nxt = PH_ESC;
        end else if (in_byte <= 8'h1f) begin
          phase_nxt = PH_CSI;
        end else if (in_byte >= 8'h30 && in_byte <= 8'h3f) begin
          if (icnt_r != '0 || pcnt_r >= PCNT_W'(CSI_LIMIT)) begin
            phase_nxt = PH_CSI_IGN;
          end else begin
            if (pcnt_r == '0) begin
              marker_nxt = in_byte;
            end else if (in_byte <= 8'h39) begin
              if (whole_ok_r) begin
                if (whole_r > digit_limit(dig)) whole_ok_nxt = 1'b0;
                else whole_nxt = (whole_r << 3) + (whole_r << 1) + {28'd0, dig};
              end
              if (field_ok_r) begin
                if (field_r > digit_limit(dig)) field_ok_nxt = 1'b0;
                else field_nxt = (field_r << 3) + (field_r << 1) + {28'd0, dig};
              end
            end else begin
              whole_ok_nxt = 1'b0;
              if (in_byte == ";") begin
                if (!seen_r && !failed_r) begin
                  if (!field_ok_r) failed_nxt = 1'b1;
                  else if (fld_match) seen_nxt = 1'b1;
                end
                field_nxt    = '0;
                field_ok_nxt = 1'b1;
              end else begin
                field_ok_nxt = 1'b0;
              end
            end
            pcnt_nxt = pcnt_r + PCNT_W'(1);
          end
        end else if (in_byte <= 8'h2f) begin
          if (icnt_r >= PCNT_W'(CSI_LIMIT)) phase_nxt = PH_CSI_IGN;
          else icnt_nxt = icnt_r + PCNT_W'(1);
        end else if (in_byte <= 8'h7e) begin
          phase_nxt = PH_GROUND;
          if (icnt_r == '0 && pcnt_r != '0) begin
            if (in_byte == "u" && marker_r == ">") begin
              cmd.push  = empty || whole_ok_r;
              cmd.value = empty ? 32'd0 : whole_r;
            end else if (in_byte == "u" && marker_r == "<") begin
              cmd.pop   = empty || whole_ok_r;
              cmd.value = empty ? 32'd1 : whole_r;
            end else if ((in_byte == "h" || in_byte == "l") && marker_r == "?" &&
                         !empty) begin
              cmd.set_scr = fin_seen;
              cmd.scr_val = (in_byte == "h");
            end
          end
        end else begin
          phase_nxt = PH_CSI_IGN;
        end
      end
      PH_CSI_IGN: begin
        if (cancel || (in_byte >= 8'h40 && in_byte <= 8'h7e)) phase_nxt = PH_GROUND;
        else if (in_byte == B_ESC) phase_nxt = PH_ESC;
      end
      PH_OSC: begin
        if (cancel || in_byte == B_BEL || in_byte == B_ST) phase_nxt = PH_GROUND;
        else if (in_byte == B_ESC) phase_nxt = PH_OSC_ESC;
      end
      PH_OSC_ESC: begin
        if (cancel || in_byte == "\\" || in_byte == B_BEL || in_byte == B_ST) begin
          phase_nxt = PH_GROUND;
        end else if (in_byte != B_ESC) begin
          phase_nxt = PH_OSC;
        end
      end
      PH_STR: begin
        if (cancel || in_byte == B_ST) phase_nxt = PH_GROUND;
        else if (in_byte == B_ESC) phase_nxt = PH_STR_ESC;
      end
      PH_STR_ESC: begin
        if (cancel || in_byte == "\\" || in_byte == B_ST) phase_nxt = PH_GROUND;
        else if (in_byte != B_ESC) phase_nxt = PH_STR;
      end
      default: begin
        phase_nxt = PH_GROUND;
        if (in_byte == B_ESC) begin
          phase_nxt = PH_ESC;
        end else if (in_byte == B_DCS || in_byte == B_SOS || in_byte == B_PM ||
                     in_byte == B_APC) begin
          phase_nxt = PH_STR;
        end else if (in_byte == B_CSI) begin
          phase_nxt    = PH_CSI;
          pcnt_nxt     = '0;
          icnt_nxt     = '0;
          marker_nxt   = '0;
          whole_nxt    = '0;
          whole_ok_nxt = 1'b1;
          field_nxt    = '0;
          field_ok_nxt = 1'b1;
          seen_nxt     = 1'b0;
          failed_nxt   = 1'b0;
        end else if (in_byte == B_OSC) begin
          phase_nxt = PH_OSC;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_GROUND;
      pcnt_r     <= '0;
      icnt_r     <= '0;
      marker_r   <= '0;
      whole_r    <= '0;
      whole_ok_r <= 1'b1;
      field_r    <= '0;
      field_ok_r <= 1'b1;
      seen_r     <= 1'b0;
      failed_r   <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      pcnt_r     <= pcnt_nxt;
      icnt_r     <= icnt_nxt;
      marker_r   <= marker_nxt;
      whole_r    <= whole_nxt;
      whole_ok_r <= whole_ok_nxt;
      field_r    <= field_nxt;
      field_ok_r <= field_ok_nxt;
      seen_r     <= seen_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eskmt_stack.sv =====
// ----------------------------------------------------------------------------
// eskmt_stack
// Both mode stacks in one memory, with ring pointers and the top-entry read.
// ----------------------------------------------------------------------------
`default_nettype none

module eskmt_stack import eskmt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire stk_cmd_t           cmd,
  input  wire logic               s1_take,
  output logic                    s1_valid,
  output logic [OUT_W-1:0]        s1_data
);

  logic [31:0] mem [2*STACK_DEPTH];

  logic [IDX_W-1:0] old_r   [2];
  logic [CNT_W-1:0] cnt_r   [2];
  logic             alt_r;
  logic [IDX_W-1:0] old_nxt [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic             alt_nxt;

  logic                 we;
  logic [IDX_W:0]       waddr;
  logic [IDX_W:0]       raddr;
  logic [IDX_W-1:0]     top_idx;
  logic [CNT_W-1:0]     cur_cnt;
  logic [IDX_W-1:0]     cur_old;

  logic             s1_valid_r;
  logic             s1_fwd_r;
  logic [31:0]      s1_val_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_alt_r;
  logic [31:0]      rd_q_r;
  logic [31:0]      top;

  assign cur_cnt = cnt_r[alt_r];
  assign cur_old = old_r[alt_r];

  always_comb begin
    old_nxt = old_r;
    cnt_nxt = cnt_r;
    alt_nxt = alt_r;
    we      = 1'b0;
    waddr   = {alt_r, cur_old};
    if (cmd.clear) begin
      old_nxt = '{default: '0};
      cnt_nxt = '{default: '0};
      alt_nxt = 1'b0;
    end else if (cmd.push) begin
      we = 1'b1;
      if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
        waddr          = {alt_r, cur_old};
        old_nxt[alt_r] = cur_old + IDX_W'(1);
      end else begin
        waddr          = {alt_r, cur_old + cur_cnt[IDX_W-1:0]};
        cnt_nxt[alt_r] = cur_cnt + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      if (cmd.value >= 32'(cur_cnt)) begin
        cnt_nxt[alt_r] = '0;
        old_nxt[alt_r] = '0;
      end else begin
        cnt_nxt[alt_r] = cur_cnt - cmd.value[CNT_W-1:0];
      end
    end else if (cmd.set_scr) begin
      alt_nxt = cmd.scr_val;
    end
    top_idx = old_nxt[alt_nxt] + cnt_nxt[alt_nxt][IDX_W-1:0] - IDX_W'(1);
    raddr   = {alt_nxt, top_idx};
  end

  always_ff @(posedge clk) begin
    if (accept && we) mem[waddr] <= cmd.value;
    if (accept) rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r      <= '{default: '0};
      cnt_r      <= '{default: '0};
      alt_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        old_r <= old_nxt;
        cnt_r <= cnt_nxt;
        alt_r <= alt_nxt;
      end
      if (accept) s1_valid_r <= 1'b1;
      else if (s1_take) s1_valid_r <= 1'b0;
    end
  end

  // a push always lands on the new top: take it straight from the command
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fwd_r <= cmd.push && !cmd.clear;
      s1_val_r <= cmd.value;
      s1_cnt_r <= cnt_nxt[alt_nxt];
      s1_alt_r <= alt_nxt;
    end
  end

  always_comb begin
    if (s1_cnt_r == '0) top = '0;
    else if (s1_fwd_r) top = s1_val_r;
    else top = rd_q_r;
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = {DEPTH_W'(s1_cnt_r), top, s1_alt_r,
                     (s1_cnt_r != '0) && ((top & FLAG_MASK) != '0)};

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_keyboard_mode_tracker.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_keyboard_mode_tracker
// Tracks the keyboard-mode stacks of a terminal from its output byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte of terminal output per item (in_tdata[7:0]).
//   out_* : one result item per input byte, giving the state after that byte.
//   Each byte is parsed and the active stack updated in the cycle it is
//   accepted; the new top entry is read from the stack memory into the read
//   stage and the result is then registered. Throughput is one byte per
//   cycle while out_tready is high, set by the single read/modify/write
//   pass over the stack memory (a push forwards its value as the new top).
//   When out_tready is low, the result register and one read stage hold up to
//   two items; in_tready drops only when both are full.
//   Reset (rst_n low, synchronous) returns the parser to ground, empties both
//   stacks and selects the main screen; stack memory contents are not cleared,
//   as only counted entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_keyboard_mode_tracker import eskmt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] in_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] special_keys_enabled, [1] alt_screen_now, [33:2] top_mode_flags,
  // [40:34] active_depth, rest zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  stk_cmd_t         cmd;
  logic             accept;
  logic             s1_valid;
  logic             s1_take;
  logic [OUT_W-1:0] s1_data;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign s1_take   = s1_valid && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid || s1_take;
  assign accept    = in_tvalid && in_tready;

  eskmt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .cmd     (cmd)
  );

  eskmt_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cmd      (cmd),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) out_data_r <= s1_data;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

`default_nettype wire

// ===== tb/escape_sequence_keyboard_mode_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_keyboard_mode_tracker_tb
// Drives terminal byte streams into the keyboard-mode tracker and checks every
// result item against an in-bench model of the parser and both mode stacks.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_keyboard_mode_tracker_tb;
  import eskmt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    S_GROUND, S_ESC, S_ESC_INTER, S_CSI, S_CSI_IGN, S_OSC, S_OSC_ESC, S_STR, S_STR_ESC
  } pstate_t;

  typedef struct packed {
    logic [6:0]  depth;
    logic [31:0] flags;
    logic        alt;
    logic        keys_on;
  } mode_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  escape_sequence_keyboard_mode_tracker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------- tracker model ----------------
  pstate_t     m_state;
  int unsigned m_pcnt, m_icnt;
  logic [7:0]  m_marker;
  logic [31:0] m_whole, m_field;
  logic        m_whole_ok, m_field_ok, m_match, m_failed;
  logic [31:0] m_stack [2][STACK_DEPTH];
  int unsigned m_oldest [2];
  int unsigned m_count [2];
  logic        m_alt;

  mode_view_t  expected_views[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  bit          hold_off = 1'b0;

  function automatic void add_digit(ref logic [31:0] v, ref logic ok, input int unsigned d);
    if (!ok) return;
    if (v > (32'hFFFF_FFFF - d) / 10) ok = 1'b0;
    else v = v * 10 + d;
  endfunction

  function automatic void close_field();
    if (!m_match && !m_failed) begin
      if (!m_field_ok) m_failed = 1'b1;
      else if (m_field == 47 || m_field == 1047 || m_field == 1049) m_match = 1'b1;
    end
    m_field = 0;
    m_field_ok = 1'b1;
  endfunction

  function automatic void open_csi();
    m_pcnt = 0; m_icnt = 0; m_marker = 0;
    m_whole = 0; m_whole_ok = 1; m_field = 0; m_field_ok = 1;
    m_match = 0; m_failed = 0;
    m_state = S_CSI;
  endfunction

  function automatic void push_flags(input logic [31:0] f);
    int s;
    s = m_alt;
    if (m_count[s] >= STACK_DEPTH) begin
      m_stack[s][m_oldest[s] % STACK_DEPTH] = f;
      m_oldest[s] = (m_oldest[s] + 1) % STACK_DEPTH;
    end else begin
      m_stack[s][(m_oldest[s] + m_count[s]) % STACK_DEPTH] = f;
      m_count[s]++;
    end
  endfunction

  function automatic void pop_flags(input logic [31:0] n);
    int s;
    s = m_alt;
    if (n >= m_count[s]) begin
      m_count[s] = 0; m_oldest[s] = 0;
    end else m_count[s] -= n;
  endfunction

  function automatic void clear_stacks();
    m_count[0] = 0; m_count[1] = 0; m_oldest[0] = 0; m_oldest[1] = 0; m_alt = 0;
  endfunction

  function automatic void csi_final(input logic [7:0] b);
    bit empty;
    if (m_icnt != 0 || m_pcnt == 0) return;
    empty = m_pcnt <= 1;
    if (b == "u" && m_marker == ">") begin
      if (empty) push_flags(0);
      else if (m_whole_ok) push_flags(m_whole);
    end else if (b == "u" && m_marker == "<") begin
      if (empty) pop_flags(1);
      else if (m_whole_ok) pop_flags(m_whole);
    end else if ((b == "h" || b == "l") && m_marker == "?" && !empty) begin
      close_field();
      if (m_match) m_alt = (b == "h");
    end
  endfunction

  function automatic void reset_tracker();
    open_csi();
    m_state = S_GROUND;
    clear_stacks();
  endfunction

  function automatic mode_view_t track_byte(input logic [7:0] b);
    mode_view_t r;
    bit cancel;
    int s;
    logic [31:0] top;
    cancel = (b == B_CAN || b == B_SUB);
    case (m_state)
      S_ESC: begin
        if (cancel) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_ESC;
        else if (b == "[") open_csi();
        else if (b == "]") m_state = S_OSC;
        else if (b == "P" || b == "X" || b == "^" || b == "_") m_state = S_STR;
        else if (b == "c") begin clear_stacks(); m_state = S_GROUND; end
        else if (b >= 8'h20 && b <= 8'h2f) m_state = S_ESC_INTER;
        else if (b >= 8'h30 && b <= 8'h7e) m_state = S_GROUND;
      end
      S_ESC_INTER: begin
        if (cancel || (b >= 8'h30 && b <= 8'h7e)) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_ESC;
      end
      S_CSI: begin
        if (cancel) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_ESC;
        else if (b <= 8'h1f) ;
        else if (b >= 8'h30 && b <= 8'h3f) begin
          if (m_icnt != 0 || m_pcnt >= CSI_LIMIT) m_state = S_CSI_IGN;
          else begin
            if (m_pcnt == 0) m_marker = b;
            else if (b <= 8'h39) begin
              add_digit(m_whole, m_whole_ok, b - 8'h30);
              add_digit(m_field, m_field_ok, b - 8'h30);
            end else begin
              m_whole_ok = 0;
              if (b == ";") close_field();
              else m_field_ok = 0;
            end
            m_pcnt++;
          end
        end else if (b <= 8'h2f) begin
          if (m_icnt >= CSI_LIMIT) m_state = S_CSI_IGN;
          else m_icnt++;
        end else if (b <= 8'h7e) begin
          csi_final(b);
          m_state = S_GROUND;
        end else m_state = S_CSI_IGN;
      end
      S_CSI_IGN: begin
        if (cancel || (b >= 8'h40 && b <= 8'h7e)) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_ESC;
      end
      S_OSC: begin
        if (cancel || b == B_BEL || b == B_ST) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_OSC_ESC;
      end
      S_OSC_ESC: begin
        if (cancel || b == "\\" || b == B_BEL || b == B_ST) m_state = S_GROUND;
        else if (b != B_ESC) m_state = S_OSC;
      end
      S_STR: begin
        if (cancel || b == B_ST) m_state = S_GROUND;
        else if (b == B_ESC) m_state = S_STR_ESC;
      end
      S_STR_ESC: begin
        if (cancel || b == "\\" || b == B_ST) m_state = S_GROUND;
        else if (b != B_ESC) m_state = S_STR;
      end
      default: begin
        m_state = S_GROUND;
        if (b == B_ESC) m_state = S_ESC;
        else if (b == B_DCS || b == B_SOS || b == B_PM || b == B_APC) m_state = S_STR;
        else if (b == B_CSI) open_csi();
        else if (b == B_OSC) m_state = S_OSC;
      end
    endcase
    s = m_alt;
    top = 0;
    if (m_count[s] != 0) top = m_stack[s][(m_oldest[s] + m_count[s] - 1) % STACK_DEPTH];
    r.keys_on = (m_count[s] != 0) && ((top & FLAG_MASK) != 0);
    r.alt = m_alt;
    r.flags = top;
    r.depth = m_count[s][6:0];
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    expected_views = {expected_views, track_byte(b)};
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  task automatic send_csi(input string body);
    if ($urandom_range(0, 1)) send_byte(B_CSI);
    else begin send_byte(B_ESC); send_byte("["); end
    send_text(body);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    mode_view_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_W-1:0];
      if (expected_views.size() == 0) report_mismatch("unexpected item", got.flags, 0);
      else begin
        want = expected_views.pop_front();
        if (got.keys_on !== want.keys_on)
          report_mismatch("special_keys_enabled", got.keys_on, want.keys_on);
        if (got.alt !== want.alt) report_mismatch("alt_screen_now", got.alt, want.alt);
        if (got.flags !== want.flags) report_mismatch("top_mode_flags", got.flags, want.flags);
        if (got.depth !== want.depth) report_mismatch("active_depth", got.depth, want.depth);
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    @(posedge clk);
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("escape_sequence_keyboard_mode_tracker_tb failed");
    $finish;
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_byte(8'h00); send_byte(8'hff);
    send_csi(">9u"); send_csi(">u"); send_csi(">4294967295u");
    send_csi(">4294967296u");                 // overflow: no push
    send_csi("<u"); send_csi("<2u");
    send_csi("?1;1049h"); send_csi(">1u");
    send_csi("?:;47l");                       // bad first field, stays alt
    send_csi("?47l"); send_csi("<99u");
    send_byte(B_OSC); send_text("ab"); send_byte(B_BEL);
    send_byte(B_ESC); send_text("P"); send_byte(B_ESC); send_text("\\");
    send_byte(B_ESC); send_text("c");
  endtask

  task automatic test_fill_stack();
    // push past the depth so the oldest entries get dropped
    for (int i = 0; i < STACK_DEPTH + 3; i++) send_csi($sformatf(">%0du", i));
    send_csi("?1047h");
    for (int i = 0; i < 6; i++) send_csi($sformatf(">%0du", $urandom));
    send_csi("?1047l");
    send_csi("<3u");
  endtask

  task automatic test_backpressure();
    int k;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      for (k = 0; k < 10; k++) send_csi(">8u");
    join
  endtask

  task automatic random_sequence();
    int    kind;
    string digs;
    kind = $urandom_range(0, 11);
    digs = $sformatf("%0d", $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20));
    case (kind)
      0, 1, 2: send_csi({">", digs, "u"});
      3, 4:    send_csi({"<", ($urandom_range(0, 2) == 0) ? "" : digs, "u"});
      5: send_csi({"?", digs, ";", ($urandom_range(0, 1) ? "1049" : "47"),
                   ($urandom_range(0, 1) ? "h" : "l")});
      6: send_csi({"?1047", ($urandom_range(0, 1) ? "h" : "l")});
      7: begin send_byte(B_ESC); send_byte(8'($urandom_range(0, 255))); end
      8: begin
        send_byte(B_ESC); send_text(($urandom_range(0, 1)) ? "c" : "]");
      end
      9: send_csi({">", digs, " u"});         // intermediate: ignored
      default: repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    endcase
    // random noise byte now and then, including cancels
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random();
    for (int i = 0; i < 210; i++) begin
      if (i == 175) idle_on = 1'b0;
      random_sequence();
    end
  endtask

  initial begin
    reset_tracker();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_stack();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("escape_sequence_keyboard_mode_tracker_tb passed");
    else $display("escape_sequence_keyboard_mode_tracker_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/eskmt_pkg.sv
rtl/eskmt_parser.sv
rtl/eskmt_stack.sv
rtl/escape_sequence_keyboard_mode_tracker.sv
tb/escape_sequence_keyboard_mode_tracker_tb.sv
